### rtl/core/emc_pkg.sv
// Package for the encoder menu controller: shared types, codes and defaults.
// No dependencies; used by every module under rtl/core.
package emc_pkg;

    localparam int EMC_VISIBLE_ROWS = 3;
    localparam int EMC_LEVEL_STEPS  = 40;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd600;

    typedef enum logic {
        MODE_POLL = 1'b0,
        MODE_LOAD = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GAIN   = 2'd1,
        EV_VOLUME = 2'd2,
        EV_LOAD   = 2'd3
    } t_ui_event;

    typedef struct packed {
        logic        valid;
        logic        advance;
    } t_flow;

endpackage

### rtl/core/emc_in_stage.sv
// Input register for the encoder menu controller.
// Depends on emc_pkg; holds one poll or load item until the core takes it.
module emc_in_stage #(
    parameter int LVL_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic signed [7:0] i_delta,
    input  logic              i_button_down,
    input  logic [31:0]       i_time_ms,
    input  logic [LVL_W-1:0]  i_load_gain,
    input  logic [LVL_W-1:0]  i_load_volume,
    input  logic              i_advance,
    output logic              o_valid,
    output emc_pkg::t_mode    o_mode,
    output logic signed [7:0] o_delta,
    output logic              o_button_down,
    output logic [31:0]       o_time_ms,
    output logic [LVL_W-1:0]  o_load_gain,
    output logic [LVL_W-1:0]  o_load_volume
);

    logic r_valid;
    logic n_valid;
    logic take;

    assign o_in_ready = !r_valid || i_advance;
    assign take       = i_in_valid && o_in_ready;
    assign n_valid    = take || (r_valid && !i_advance);
    assign o_valid    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_mode        <= emc_pkg::t_mode'(i_mode);
            o_delta       <= i_delta;
            o_button_down <= i_button_down;
            o_time_ms     <= i_time_ms;
            o_load_gain   <= i_load_gain;
            o_load_volume <= i_load_volume;
        end
    end

endmodule

### rtl/core/emc_core.sv
// Menu state and per-item update logic for the encoder menu controller.
// Depends on emc_pkg; holds configuration and menu state, produces the next result.
module emc_core #(
    parameter int VISIBLE_ROWS = emc_pkg::EMC_VISIBLE_ROWS,
    parameter int LEVEL_STEPS  = emc_pkg::EMC_LEVEL_STEPS,
    parameter int LVL_W        = $clog2(LEVEL_STEPS + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [emc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  emc_pkg::t_flow                 i_flow,
    input  emc_pkg::t_mode                 i_mode,
    input  logic signed [7:0]              i_delta,
    input  logic                           i_button_down,
    input  logic [31:0]                    i_time_ms,
    input  logic [LVL_W-1:0]               i_load_gain,
    input  logic [LVL_W-1:0]               i_load_volume,
    output emc_pkg::t_ui_event             o_ui_event,
    output logic [LVL_W-1:0]               o_gain_level,
    output logic [LVL_W-1:0]               o_volume_level,
    output logic [7:0]                     o_chosen_index,
    output logic                           o_list_screen,
    output logic [7:0]                     o_cursor_index,
    output logic [7:0]                     o_window_top,
    output logic                           o_editing_volume,
    output logic                           o_redraw
);

    localparam int SUM_W = ((LVL_W > 8) ? LVL_W : 8) + 2;
    localparam logic [LVL_W-1:0] LVL_MAX  = LVL_W'(LEVEL_STEPS);
    localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(LEVEL_STEPS / 2);
    localparam logic [8:0]       ROWS9    = 9'(VISIBLE_ROWS);
    localparam logic [7:0]       ROWS_M1  = 8'(VISIBLE_ROWS - 1);

    logic [7:0]       r_list_count;
    logic [15:0]      r_long_ms;
    logic             r_screen;
    logic             r_vol_edit;
    logic [7:0]       r_cursor;
    logic [7:0]       r_scroll;
    logic [7:0]       r_choice;
    logic [LVL_W-1:0] r_gain;
    logic [LVL_W-1:0] r_volume;
    logic             r_was_down;
    logic [31:0]      r_press_start;

    logic             n_screen;
    logic             n_vol_edit;
    logic [7:0]       n_cursor;
    logic [7:0]       n_scroll;
    logic [7:0]       n_choice;
    logic [LVL_W-1:0] n_gain;
    logic [LVL_W-1:0] n_volume;
    logic             n_was_down;
    logic [31:0]      n_press_start;
    emc_pkg::t_ui_event n_event;
    logic             n_dirty;

    logic [31:0]      held;
    logic             quick_rel;
    logic             slow_rel;
    logic             rise;
    logic             fall;
    logic [LVL_W-1:0] ld_gain;
    logic [LVL_W-1:0] ld_volume;
    logic [LVL_W-1:0] moved_level;
    logic signed [SUM_W-1:0] lvl_sum;
    logic signed [9:0] cur_sum;
    logic [7:0]       cur_new;
    logic             delta_nz;

    assign rise     = i_button_down && !r_was_down;
    assign fall     = !i_button_down && r_was_down;
    assign held     = i_time_ms - r_press_start;
    assign slow_rel  = fall && (held >= {16'd0, r_long_ms});
    assign quick_rel = fall && !(held >= {16'd0, r_long_ms});
    assign delta_nz = (i_delta != 8'sd0);

    assign ld_gain   = (i_load_gain > LVL_MAX) ? LVL_MAX : i_load_gain;
    assign ld_volume = (i_load_volume > LVL_MAX) ? LVL_MAX : i_load_volume;

    assign lvl_sum = $signed(SUM_W'(r_vol_edit ? r_volume : r_gain)) + SUM_W'(i_delta);

    always_comb begin
        if (lvl_sum < 0) begin
            moved_level = '0;
        end else if (lvl_sum > $signed(SUM_W'(LEVEL_STEPS))) begin
            moved_level = LVL_MAX;
        end else begin
            moved_level = lvl_sum[LVL_W-1:0];
        end
    end

    assign cur_sum = $signed({2'b00, r_cursor}) + 10'(i_delta);

    always_comb begin
        if (cur_sum < 0) begin
            cur_new = 8'd0;
        end else if (cur_sum >= $signed({2'b00, r_list_count})) begin
            cur_new = r_list_count - 8'd1;
        end else begin
            cur_new = cur_sum[7:0];
        end
    end

    always_comb begin
        n_screen      = r_screen;
        n_vol_edit    = r_vol_edit;
        n_cursor      = r_cursor;
        n_scroll      = r_scroll;
        n_choice      = r_choice;
        n_gain        = r_gain;
        n_volume      = r_volume;
        n_was_down    = r_was_down;
        n_press_start = r_press_start;
        n_event       = emc_pkg::EV_NONE;
        n_dirty       = 1'b0;
        unique case (i_mode)
            emc_pkg::MODE_LOAD: begin
                n_gain   = ld_gain;
                n_volume = ld_volume;
                n_dirty  = (ld_gain != r_gain) || (ld_volume != r_volume);
            end
            default: begin
                if (rise) begin
                    n_press_start = i_time_ms;
                    n_was_down    = 1'b1;
                end else if (fall) begin
                    n_was_down = 1'b0;
                end
                if (!r_screen) begin
                    if (delta_nz) begin
                        if (r_vol_edit) begin
                            n_volume = moved_level;
                            n_event  = emc_pkg::EV_VOLUME;
                        end else begin
                            n_gain  = moved_level;
                            n_event = emc_pkg::EV_GAIN;
                        end
                        n_dirty = 1'b1;
                    end
                    if (quick_rel) begin
                        n_vol_edit = !r_vol_edit;
                        n_dirty    = 1'b1;
                    end
                    if (slow_rel) begin
                        n_screen = 1'b1;
                        n_dirty  = 1'b1;
                    end
                end else begin
                    if (delta_nz && (r_list_count != 8'd0)) begin
                        n_cursor = cur_new;
                        if (cur_new < r_scroll) begin
                            n_scroll = cur_new;
                        end else if ({1'b0, cur_new} >= ({1'b0, r_scroll} + ROWS9)) begin
                            n_scroll = cur_new - ROWS_M1;
                        end
                        n_dirty = 1'b1;
                    end
                    if (quick_rel && (r_list_count != 8'd0)) begin
                        n_choice = n_cursor;
                        n_screen = 1'b0;
                        n_event  = emc_pkg::EV_LOAD;
                        n_dirty  = 1'b1;
                    end
                    if (slow_rel) begin
                        n_screen = 1'b0;
                        n_dirty  = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count  <= 8'd0;
            r_long_ms     <= emc_pkg::LONG_PRESS_RESET;
            r_screen      <= 1'b0;
            r_vol_edit    <= 1'b0;
            r_cursor      <= 8'd0;
            r_scroll      <= 8'd0;
            r_choice      <= 8'd0;
            r_gain        <= LVL_HALF;
            r_volume      <= LVL_MAX;
            r_was_down    <= 1'b0;
            r_press_start <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                emc_pkg::CFG_LIST_COUNT: begin
                    r_list_count <= i_cfg_data[7:0];
                    r_cursor     <= 8'd0;
                    r_scroll     <= 8'd0;
                end
                emc_pkg::CFG_LONG_PRESS: begin
                    r_long_ms <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end else if (i_flow.advance) begin
            r_screen      <= n_screen;
            r_vol_edit    <= n_vol_edit;
            r_cursor      <= n_cursor;
            r_scroll      <= n_scroll;
            r_choice      <= n_choice;
            r_gain        <= n_gain;
            r_volume      <= n_volume;
            r_was_down    <= n_was_down;
            r_press_start <= n_press_start;
        end
    end

    assign o_ui_event       = n_event;
    assign o_gain_level     = n_gain;
    assign o_volume_level   = n_volume;
    assign o_chosen_index   = n_choice;
    assign o_list_screen    = n_screen;
    assign o_cursor_index   = n_cursor;
    assign o_window_top     = n_scroll;
    assign o_editing_volume = n_vol_edit;
    assign o_redraw         = n_dirty && i_flow.valid;

endmodule

### rtl/core/emc_out_stage.sv
// Result register for the encoder menu controller.
// Depends on emc_pkg; holds one result until the consumer takes it.
module emc_out_stage #(
    parameter int LVL_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_advance,
    input  emc_pkg::t_ui_event i_ui_event,
    input  logic [LVL_W-1:0]   i_gain_level,
    input  logic [LVL_W-1:0]   i_volume_level,
    input  logic [7:0]         i_chosen_index,
    input  logic               i_list_screen,
    input  logic [7:0]         i_cursor_index,
    input  logic [7:0]         i_window_top,
    input  logic               i_editing_volume,
    input  logic               i_redraw,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_ui_event,
    output logic [LVL_W-1:0]   o_gain_level,
    output logic [LVL_W-1:0]   o_volume_level,
    output logic [7:0]         o_chosen_index,
    output logic               o_list_screen,
    output logic [7:0]         o_cursor_index,
    output logic [7:0]         o_window_top,
    output logic               o_editing_volume,
    output logic               o_redraw
);

    logic r_valid;
    logic n_valid;

    assign o_advance   = i_in_valid && (!r_valid || i_out_ready);
    assign n_valid     = o_advance || (r_valid && !i_out_ready);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            o_ui_event       <= i_ui_event;
            o_gain_level     <= i_gain_level;
            o_volume_level   <= i_volume_level;
            o_chosen_index   <= i_chosen_index;
            o_list_screen    <= i_list_screen;
            o_cursor_index   <= i_cursor_index;
            o_window_top     <= i_window_top;
            o_editing_volume <= i_editing_volume;
            o_redraw         <= i_redraw;
        end
    end

endmodule

### rtl/core/encoder_menu_controller.sv
// Data path: input register, combinational menu update, result register.
// Throughput: one item per cycle unless the consumer stalls; both registers run
// concurrently and the menu update is one level of compare and saturate logic.
// Reset: synchronous, active low; clears handshake state, menu state and registers
// (gain LEVEL_STEPS/2, volume LEVEL_STEPS, long press 600 ms). Uses emc_pkg.
module encoder_menu_controller #(
    parameter int VISIBLE_ROWS = emc_pkg::EMC_VISIBLE_ROWS,
    parameter int LEVEL_STEPS  = emc_pkg::EMC_LEVEL_STEPS,
    parameter int LVL_W        = $clog2(LEVEL_STEPS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [emc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic signed [7:0]             i_delta,
    input  logic                          i_button_down,
    input  logic [31:0]                   i_time_ms,
    input  logic [LVL_W-1:0]              i_load_gain,
    input  logic [LVL_W-1:0]              i_load_volume,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_ui_event,
    output logic [LVL_W-1:0]              o_gain_level,
    output logic [LVL_W-1:0]              o_volume_level,
    output logic [7:0]                    o_chosen_index,
    output logic                          o_list_screen,
    output logic [7:0]                    o_cursor_index,
    output logic [7:0]                    o_window_top,
    output logic                          o_editing_volume,
    output logic                          o_redraw
);

    emc_pkg::t_flow     flow;
    logic               advance;
    logic               item_valid;
    emc_pkg::t_mode     item_mode;
    logic signed [7:0]  item_delta;
    logic               item_down;
    logic [31:0]        item_time;
    logic [LVL_W-1:0]   item_gain;
    logic [LVL_W-1:0]   item_volume;

    emc_pkg::t_ui_event nx_event;
    logic [LVL_W-1:0]   nx_gain;
    logic [LVL_W-1:0]   nx_volume;
    logic [7:0]         nx_choice;
    logic               nx_screen;
    logic [7:0]         nx_cursor;
    logic [7:0]         nx_scroll;
    logic               nx_vol_edit;
    logic               nx_redraw;

    assign o_cfg_ready  = 1'b1;
    assign flow.valid   = item_valid;
    assign flow.advance = advance;

    emc_in_stage #(
        .LVL_W(LVL_W)
    ) u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_delta       (i_delta),
        .i_button_down (i_button_down),
        .i_time_ms     (i_time_ms),
        .i_load_gain   (i_load_gain),
        .i_load_volume (i_load_volume),
        .i_advance     (advance),
        .o_valid       (item_valid),
        .o_mode        (item_mode),
        .o_delta       (item_delta),
        .o_button_down (item_down),
        .o_time_ms     (item_time),
        .o_load_gain   (item_gain),
        .o_load_volume (item_volume)
    );

    emc_core #(
        .VISIBLE_ROWS(VISIBLE_ROWS),
        .LEVEL_STEPS (LEVEL_STEPS),
        .LVL_W       (LVL_W)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_flow           (flow),
        .i_mode           (item_mode),
        .i_delta          (item_delta),
        .i_button_down    (item_down),
        .i_time_ms        (item_time),
        .i_load_gain      (item_gain),
        .i_load_volume    (item_volume),
        .o_ui_event       (nx_event),
        .o_gain_level     (nx_gain),
        .o_volume_level   (nx_volume),
        .o_chosen_index   (nx_choice),
        .o_list_screen    (nx_screen),
        .o_cursor_index   (nx_cursor),
        .o_window_top     (nx_scroll),
        .o_editing_volume (nx_vol_edit),
        .o_redraw         (nx_redraw)
    );

    emc_out_stage #(
        .LVL_W(LVL_W)
    ) u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (item_valid),
        .o_advance        (advance),
        .i_ui_event       (nx_event),
        .i_gain_level     (nx_gain),
        .i_volume_level   (nx_volume),
        .i_chosen_index   (nx_choice),
        .i_list_screen    (nx_screen),
        .i_cursor_index   (nx_cursor),
        .i_window_top     (nx_scroll),
        .i_editing_volume (nx_vol_edit),
        .i_redraw         (nx_redraw),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ui_event       (o_ui_event),
        .o_gain_level     (o_gain_level),
        .o_volume_level   (o_volume_level),
        .o_chosen_index   (o_chosen_index),
        .o_list_screen    (o_list_screen),
        .o_cursor_index   (o_cursor_index),
        .o_window_top     (o_window_top),
        .o_editing_volume (o_editing_volume),
        .o_redraw         (o_redraw)
    );

endmodule

### rtl/core/emc_checker.sv
// Port-level checker for encoder_menu_controller, attached with bind.
// Depends on emc_pkg and on the top level's ports only.
module emc_checker #(
    parameter int VISIBLE_ROWS = emc_pkg::EMC_VISIBLE_ROWS,
    parameter int LEVEL_STEPS  = emc_pkg::EMC_LEVEL_STEPS,
    parameter int LVL_W        = $clog2(LEVEL_STEPS + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       o_ui_event,
    input logic [LVL_W-1:0] o_gain_level,
    input logic [LVL_W-1:0] o_volume_level,
    input logic             o_list_screen,
    input logic [7:0]       o_cursor_index,
    input logic [7:0]       o_window_top,
    input logic             o_redraw
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before transfer");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_gain_level <= LVL_W'(LEVEL_STEPS))
                         && (o_volume_level <= LVL_W'(LEVEL_STEPS))))
        else $error("level above full scale");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_cursor_index >= o_window_top)
            && ({1'b0, o_cursor_index} < ({1'b0, o_window_top} + 9'(VISIBLE_ROWS)))))
        else $error("cursor outside scroll window");

    a_load_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_ui_event == emc_pkg::EV_LOAD)) |-> !o_list_screen)
        else $error("load event while list screen stays open");

    a_event_redraw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_ui_event != emc_pkg::EV_NONE)) |-> o_redraw)
        else $error("event without redraw");

endmodule

bind encoder_menu_controller emc_checker #(
    .VISIBLE_ROWS(VISIBLE_ROWS),
    .LEVEL_STEPS (LEVEL_STEPS),
    .LVL_W       (LVL_W)
) u_emc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_ui_event     (o_ui_event),
    .o_gain_level   (o_gain_level),
    .o_volume_level (o_volume_level),
    .o_list_screen  (o_list_screen),
    .o_cursor_index (o_cursor_index),
    .o_window_top   (o_window_top),
    .o_redraw       (o_redraw)
);

### bench/tb.sv
// Self-checking bench for encoder_menu_controller: directed and random poll/load items
// against a cycle-free menu predictor, with config writes between traffic phases.
// Depends on emc_pkg and the encoder_menu_controller RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LVL_W = $clog2(emc_pkg::EMC_LEVEL_STEPS + 1);
    localparam logic [emc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [emc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int SEG_RANDOM = -1;
    localparam int SEG_N = 10;
    localparam int SEG_ITEMS = 125;
    localparam int SEG_COUNT [SEG_N] = '{3, 0, 255, 1, 2, SEG_RANDOM, 4, 255, SEG_RANDOM, 5};
    localparam int SEG_LONG [SEG_N] =
        '{600, 40, 65535, 1, 0, SEG_RANDOM, 300, 1, SEG_RANDOM, 600};

    typedef struct packed {
        emc_pkg::t_mode   mode;
        logic [7:0]       delta;
        logic             button_down;
        logic [31:0]      time_ms;
        logic [LVL_W-1:0] load_gain;
        logic [LVL_W-1:0] load_volume;
    } t_panel_item;

    typedef struct packed {
        emc_pkg::t_ui_event ui_event;
        logic [LVL_W-1:0]   gain;
        logic [LVL_W-1:0]   volume;
        logic [7:0]         chosen;
        logic               list_screen;
        logic [7:0]         cursor;
        logic [7:0]         window_top;
        logic               editing_volume;
        logic               redraw;
    } t_panel_view;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [emc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          i_out_ready = 1'b0;
    t_panel_item                   in_item = '0;
    logic                          o_cfg_ready;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic [1:0]                    o_ui_event;
    logic [LVL_W-1:0]              o_gain_level;
    logic [LVL_W-1:0]              o_volume_level;
    logic [7:0]                    o_chosen_index;
    logic                          o_list_screen;
    logic [7:0]                    o_cursor_index;
    logic [7:0]                    o_window_top;
    logic                          o_editing_volume;
    logic                          o_redraw;
    t_panel_view                   dut_view;

    t_panel_item poll_backlog [$];
    t_panel_view view_expected [$];
    logic        in_taken = 1'b0;
    logic        cfg_taken = 1'b0;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 64;
    int          items_queued = 0;
    int          bad_results = 0;

    // predicted menu state, reset values
    logic        m_on_list = 1'b0;
    logic        m_edit_vol = 1'b0;
    logic [7:0]  m_cursor = '0;
    logic [7:0]  m_window = '0;
    logic [7:0]  m_choice = '0;
    int          m_gain = emc_pkg::EMC_LEVEL_STEPS / 2;
    int          m_volume = emc_pkg::EMC_LEVEL_STEPS;
    logic        m_down = 1'b0;
    logic [31:0] m_press_t = '0;
    logic [7:0]  m_list_count = '0;
    logic [15:0] m_long_ms = emc_pkg::LONG_PRESS_RESET;

    encoder_menu_controller DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (in_item.mode),
        .i_delta          (in_item.delta),
        .i_button_down    (in_item.button_down),
        .i_time_ms        (in_item.time_ms),
        .i_load_gain      (in_item.load_gain),
        .i_load_volume    (in_item.load_volume),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ui_event       (o_ui_event),
        .o_gain_level     (o_gain_level),
        .o_volume_level   (o_volume_level),
        .o_chosen_index   (o_chosen_index),
        .o_list_screen    (o_list_screen),
        .o_cursor_index   (o_cursor_index),
        .o_window_top     (o_window_top),
        .o_editing_volume (o_editing_volume),
        .o_redraw         (o_redraw)
    );

    assign dut_view = {o_ui_event, o_gain_level, o_volume_level, o_chosen_index, o_list_screen,
                       o_cursor_index, o_window_top, o_editing_volume, o_redraw};

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int clamp_level(int lvl);
        if (lvl < 0) return 0;
        if (lvl > emc_pkg::EMC_LEVEL_STEPS) return emc_pkg::EMC_LEVEL_STEPS;
        return lvl;
    endfunction

    function automatic t_panel_view advance_menu(t_panel_item it);
        t_panel_view v;
        logic [31:0] held;
        int          d;
        int          lvl_g;
        int          lvl_v;
        int          nxt;
        logic        short_p;
        logic        long_p;
        v = '0;
        v.ui_event = emc_pkg::EV_NONE;
        short_p = 1'b0;
        long_p = 1'b0;
        if (it.mode == emc_pkg::MODE_LOAD) begin
            lvl_g = (it.load_gain > emc_pkg::EMC_LEVEL_STEPS) ? emc_pkg::EMC_LEVEL_STEPS
                                                               : int'(it.load_gain);
            lvl_v = (it.load_volume > emc_pkg::EMC_LEVEL_STEPS) ? emc_pkg::EMC_LEVEL_STEPS
                                                                 : int'(it.load_volume);
            if (lvl_g != m_gain || lvl_v != m_volume) v.redraw = 1'b1;
            m_gain = lvl_g;
            m_volume = lvl_v;
        end else begin
            d = $signed(it.delta);
            if (it.button_down && !m_down) begin
                m_press_t = it.time_ms;
                m_down = 1'b1;
            end else if (!it.button_down && m_down) begin
                held = it.time_ms - m_press_t;
                m_down = 1'b0;
                if (held >= {16'd0, m_long_ms}) long_p = 1'b1;
                else short_p = 1'b1;
            end
            if (!m_on_list) begin
                if (d != 0) begin
                    if (m_edit_vol) begin
                        m_volume = clamp_level(m_volume + d);
                        v.ui_event = emc_pkg::EV_VOLUME;
                    end else begin
                        m_gain = clamp_level(m_gain + d);
                        v.ui_event = emc_pkg::EV_GAIN;
                    end
                    v.redraw = 1'b1;
                end
                if (short_p) begin
                    m_edit_vol = !m_edit_vol;
                    v.redraw = 1'b1;
                end
                if (long_p) begin
                    m_on_list = 1'b1;
                    v.redraw = 1'b1;
                end
            end else begin
                if (d != 0 && m_list_count != 0) begin
                    nxt = int'(m_cursor) + d;
                    if (nxt < 0) nxt = 0;
                    if (nxt >= int'(m_list_count)) nxt = int'(m_list_count) - 1;
                    m_cursor = nxt[7:0];
                    if (m_cursor < m_window)
                        m_window = m_cursor;
                    else if (int'(m_cursor) >= int'(m_window) + emc_pkg::EMC_VISIBLE_ROWS)
                        m_window = m_cursor - 8'(emc_pkg::EMC_VISIBLE_ROWS - 1);
                    v.redraw = 1'b1;
                end
                if (short_p && m_list_count != 0) begin
                    m_choice = m_cursor;
                    m_on_list = 1'b0;
                    v.ui_event = emc_pkg::EV_LOAD;
                    v.redraw = 1'b1;
                end
                if (long_p) begin
                    m_on_list = 1'b0;
                    v.redraw = 1'b1;
                end
            end
        end
        v.gain = m_gain[LVL_W-1:0];
        v.volume = m_volume[LVL_W-1:0];
        v.chosen = m_choice;
        v.list_screen = m_on_list;
        v.cursor = m_cursor;
        v.window_top = m_window;
        v.editing_volume = m_edit_vol;
        return v;
    endfunction

    function automatic string view_str(t_panel_view v);
        return $sformatf(
            "ev=%0d gain=%0d vol=%0d pick=%0d list=%0d cur=%0d top=%0d edv=%0d redraw=%0d",
            v.ui_event, v.gain, v.volume, v.chosen, v.list_screen, v.cursor,
            v.window_top, v.editing_volume, v.redraw);
    endfunction

    function automatic int pick_clicks();
        if ($urandom_range(9) == 0) return int'($urandom_range(255)) - 128;
        return int'($urandom_range(12)) - 6;
    endfunction

    task automatic queue_poll(input int clicks, input logic down, input logic [31:0] t);
        t_panel_item it;
        it.mode = emc_pkg::MODE_POLL;
        it.delta = clicks[7:0];
        it.button_down = down;
        it.time_ms = t;
        it.load_gain = LVL_W'($urandom());
        it.load_volume = LVL_W'($urandom());
        poll_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic queue_load(input int g, input int v);
        t_panel_item it;
        it.mode = emc_pkg::MODE_LOAD;
        it.delta = 8'($urandom());
        it.button_down = 1'($urandom());
        it.time_ms = $urandom();
        it.load_gain = g[LVL_W-1:0];
        it.load_volume = v[LVL_W-1:0];
        poll_backlog.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [emc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (poll_backlog.size() != 0 || i_in_valid || view_expected.size() != 0);
    endtask

    // item driver and result backpressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (poll_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_item <= poll_backlog.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // transfer monitor, prediction and checking
    always @(posedge i_clk) begin : monitor
        t_panel_view want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (view_expected.size() == 0) begin
                    if (bad_results < 10) $display("unexpected result: %s", view_str(dut_view));
                    bad_results++;
                end else begin
                    want = view_expected.pop_front();
                    if (dut_view !== want) begin
                        if (bad_results < 10)
                            $display("mismatch at %0t\n  exp %s\n  got %s", $realtime,
                                     view_str(want), view_str(dut_view));
                        bad_results++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    emc_pkg::CFG_LIST_COUNT: begin
                        m_list_count = i_cfg_data[7:0];
                        m_cursor = '0;
                        m_window = '0;
                    end
                    emc_pkg::CFG_LONG_PRESS: m_long_ms = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) view_expected.push_back(advance_menu(in_item));
        end
    end

    initial begin : stimulus
        logic [31:0] gen_time;
        logic [31:0] t_press;
        logic [31:0] held;
        logic [31:0] data;
        logic        g_down;
        int          r;
        int          k;
        int          lp;
        int          cnt;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // home screen: saturation, swap, loads, wrapped long press, empty list
        queue_poll(127, 1'b0, 10);
        queue_poll(1, 1'b0, 20);
        queue_poll(-128, 1'b0, 30);
        queue_poll(-1, 1'b0, 40);
        queue_poll(0, 1'b1, 100);
        queue_poll(0, 1'b0, 150);
        queue_poll(-128, 1'b0, 160);
        queue_load(63, 63);
        queue_load(40, 40);
        queue_poll(5, 1'b1, 32'hFFFF_FF00);
        queue_poll(3, 1'b0, 32'h0000_0158);
        queue_poll(5, 1'b0, 400);
        queue_poll(0, 1'b1, 1000);
        queue_poll(0, 1'b0, 1010);
        queue_poll(0, 1'b1, 2000);
        queue_poll(-2, 1'b0, 2600);
        wait_idle();
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        write_reg(emc_pkg::CFG_LIST_COUNT, 32'd255);
        write_reg(emc_pkg::CFG_LONG_PRESS, 32'd1);
        // full list: cursor clamp, window drag, short press loads
        queue_poll(0, 1'b1, 7);
        queue_poll(0, 1'b0, 8);
        queue_poll(127, 1'b0, 9);
        queue_poll(127, 1'b0, 10);
        queue_poll(127, 1'b0, 11);
        queue_poll(-128, 1'b0, 12);
        queue_poll(0, 1'b1, 30);
        queue_poll(1, 1'b0, 30);
        wait_idle();
        write_reg(emc_pkg::CFG_LIST_COUNT, 32'd1);
        write_reg(emc_pkg::CFG_LONG_PRESS, 32'd0);
        // zero threshold: zero hold time is long
        queue_poll(0, 1'b1, 0);
        queue_poll(0, 1'b0, 0);
        queue_poll(-5, 1'b0, 1);

        gen_time = $urandom();
        g_down = 1'b0;
        for (int seg = 0; seg < SEG_N; seg++) begin
            wait_idle();
            if (seg == 4) begin
                send_idle_pct = 64;
                recv_idle_pct = 17;
            end else if (seg == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cnt = (SEG_COUNT[seg] == SEG_RANDOM) ? $urandom_range(255) : SEG_COUNT[seg];
            lp = (SEG_LONG[seg] == SEG_RANDOM) ? $urandom_range(2000) : SEG_LONG[seg];
            data = $urandom();
            data[7:0] = cnt[7:0];
            write_reg(emc_pkg::CFG_LIST_COUNT, data);
            data = $urandom();
            data[15:0] = lp[15:0];
            write_reg(emc_pkg::CFG_LONG_PRESS, data);
            items_queued = 0;
            while (items_queued < SEG_ITEMS) begin
                r = $urandom_range(99);
                if (r < 30) begin
                    gen_time += $urandom_range(40);
                    queue_poll(pick_clicks(), g_down, gen_time);
                end else if (r < 72) begin
                    gen_time += $urandom_range(40);
                    t_press = gen_time;
                    queue_poll(($urandom_range(3) == 0) ? pick_clicks() : 0, 1'b1, t_press);
                    k = $urandom_range(9);
                    if (k < 4) held = (lp == 0) ? 0 : $urandom_range(lp - 1);
                    else if (k < 8) held = lp + $urandom_range(300);
                    else if (k == 8) held = lp + $urandom_range(2) - 1;
                    else held = $urandom();
                    repeat ($urandom_range(3)) queue_poll(pick_clicks(), 1'b1, t_press + held / 2);
                    gen_time = t_press + held;
                    queue_poll(($urandom_range(2) == 0) ? pick_clicks() : 0, 1'b0, gen_time);
                    g_down = 1'b0;
                end else if (r < 82) begin
                    if ($urandom_range(4) == 0)
                        queue_load($urandom_range(63), $urandom_range(63));
                    else
                        queue_load($urandom_range(emc_pkg::EMC_LEVEL_STEPS),
                                   $urandom_range(emc_pkg::EMC_LEVEL_STEPS));
                end else if (r < 92) begin
                    g_down = 1'($urandom());
                    queue_poll(int'($urandom_range(255)) - 128, g_down, $urandom());
                end else begin
                    queue_load($urandom_range(63), $urandom_range(63));
                end
            end
        end

        wait_idle();
        repeat (4) @(negedge i_clk);
        bad_results += view_expected.size();
        if (bad_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
